// ===== sv/mcdn_pkg.sv =====
// shared constants for the distinct-neighbor min cost block
// no dependencies
`default_nettype none

package mcdn_pkg;

    localparam int SUM_W = 32;
    localparam logic [SUM_W-1:0] SUM_CEIL = {SUM_W{1'b1}};

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;
    localparam logic [CFG_W-1:0] MIN_CHOICES = 4'd2;

    localparam int DEF_MAX_CHOICES = 8;
    localparam int DEF_COST_WIDTH  = 16;

endpackage

`default_nettype wire

// ===== sv/mcdn_min2.sv =====
// two-smallest search over the stored path costs, gives each lane its best other cost
// depends on mcdn_pkg
`default_nettype none

module mcdn_min2 #(
    parameter int MAX_CHOICES = mcdn_pkg::DEF_MAX_CHOICES
) (
    input  wire logic [MAX_CHOICES-1:0]                        i_active,
    input  wire logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   i_cost,
    output logic      [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   o_other
);

    localparam int NP2   = 1 << $clog2(MAX_CHOICES);
    localparam int IDX_W = $clog2(NP2);

    logic [NP2-1:0][mcdn_pkg::SUM_W-1:0] w_leaf;
    logic [mcdn_pkg::SUM_W-1:0]          w_best;
    logic [mcdn_pkg::SUM_W-1:0]          w_second;
    logic [IDX_W-1:0]                    w_idx;

    // inactive and padding entries read as the ceiling
    for (genvar g = 0; g < NP2; g++) begin : g_leaf
        if (g < MAX_CHOICES) begin : g_real
            assign w_leaf[g] = i_active[g] ? i_cost[g] : mcdn_pkg::SUM_CEIL;
        end else begin : g_pad
            assign w_leaf[g] = mcdn_pkg::SUM_CEIL;
        end
    end

    always_comb begin
        logic [NP2-1:0][mcdn_pkg::SUM_W-1:0] best;
        logic [NP2-1:0][mcdn_pkg::SUM_W-1:0] second;
        logic [NP2-1:0][IDX_W-1:0]           idx;
        best = w_leaf;
        for (int i = 0; i < NP2; i++) begin
            second[i] = mcdn_pkg::SUM_CEIL;
            idx[i]    = IDX_W'(i);
        end
        // lower index wins ties
        for (int s = 1; s < NP2; s = s * 2) begin
            for (int i = 0; i < NP2; i = i + 2 * s) begin
                if (best[i+s] < best[i]) begin
                    second[i] = (best[i] < second[i+s]) ? best[i] : second[i+s];
                    best[i]   = best[i+s];
                    idx[i]    = idx[i+s];
                end else begin
                    second[i] = (second[i] < best[i+s]) ? second[i] : best[i+s];
                end
            end
        end
        w_best   = best[0];
        w_second = second[0];
        w_idx    = idx[0];
    end

    for (genvar c = 0; c < MAX_CHOICES; c++) begin : g_other
        assign o_other[c] = (w_idx == IDX_W'(c)) ? w_second : w_best;
    end

endmodule

`default_nettype wire

// ===== sv/mcdn_lane.sv =====
// one choice lane: own cost plus best other path cost, saturated at the ceiling
// depends on mcdn_pkg
`default_nettype none

module mcdn_lane #(
    parameter int COST_WIDTH = mcdn_pkg::DEF_COST_WIDTH
) (
    input  wire logic                         i_active,
    input  wire logic [COST_WIDTH-1:0]        i_own,
    input  wire logic [mcdn_pkg::SUM_W-1:0]   i_other,
    output logic      [mcdn_pkg::SUM_W-1:0]   o_store,
    output logic      [mcdn_pkg::SUM_W-1:0]   o_cand,
    output logic                              o_sat
);

    logic [mcdn_pkg::SUM_W:0]   w_sum;
    logic [mcdn_pkg::SUM_W-1:0] w_fresh;

    assign w_sum   = (mcdn_pkg::SUM_W+1)'(i_own) + {1'b0, i_other};
    assign w_fresh = w_sum[mcdn_pkg::SUM_W] ? mcdn_pkg::SUM_CEIL : w_sum[mcdn_pkg::SUM_W-1:0];

    assign o_sat   = i_active & w_sum[mcdn_pkg::SUM_W];
    assign o_store = i_active ? w_fresh : '0;
    assign o_cand  = i_active ? w_fresh : mcdn_pkg::SUM_CEIL;

endmodule

`default_nettype wire

// ===== sv/mcdn_merge.sv =====
// end-of-row stage: holds lane results, takes their minimum, output register
// depends on mcdn_pkg
`default_nettype none

module mcdn_merge #(
    parameter int MAX_CHOICES = mcdn_pkg::DEF_MAX_CHOICES
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_load,
    input  wire logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   i_cand,
    input  wire logic                                          i_sat,
    output logic                                               o_ready,
    output logic                                               o_valid,
    input  wire logic                                          i_out_ready,
    output logic      [mcdn_pkg::SUM_W-1:0]                    o_min,
    output logic                                               o_sat
);

    localparam int NP2 = 1 << $clog2(MAX_CHOICES);

    logic                                          r_s1_valid;
    logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   r_s1_cand;
    logic                                          r_s1_sat;
    logic                                          r_out_valid;
    logic [mcdn_pkg::SUM_W-1:0]                    r_out_min;
    logic                                          r_out_sat;

    logic                                          w_out_free;
    logic [NP2-1:0][mcdn_pkg::SUM_W-1:0]           w_leaf;
    logic [mcdn_pkg::SUM_W-1:0]                    n_min;

    assign w_out_free = ~r_out_valid | i_out_ready;
    assign o_ready    = ~r_s1_valid | w_out_free;

    for (genvar g = 0; g < NP2; g++) begin : g_leaf
        if (g < MAX_CHOICES) begin : g_real
            assign w_leaf[g] = r_s1_cand[g];
        end else begin : g_pad
            assign w_leaf[g] = mcdn_pkg::SUM_CEIL;
        end
    end

    always_comb begin
        logic [NP2-1:0][mcdn_pkg::SUM_W-1:0] m;
        m = w_leaf;
        for (int s = 1; s < NP2; s = s * 2) begin
            for (int i = 0; i < NP2; i = i + 2 * s) begin
                if (m[i+s] < m[i]) begin
                    m[i] = m[i+s];
                end
            end
        end
        n_min = m[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_load;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_cand <= i_cand;
            r_s1_sat  <= i_sat;
        end
        if (w_out_free && r_s1_valid) begin
            r_out_min <= n_min;
            r_out_sat <= r_s1_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_min   = r_out_min;
    assign o_sat   = r_out_sat;

endmodule

`default_nettype wire

// ===== sv/min_cost_distinct_neighbor_dp.sv =====
// Minimum-cost row colouring with no two equal neighboring choices. Each request on the
// input stream is one position of a row carrying one cost per choice; the block takes one
// request every clock unless the output path stalls it. The stored path costs feed a
// two-smallest search and the per-choice lane adders, and the result is written back in
// the same cycle, so that loop sets the rate. On the request marked tlast the minimum total
// and the saturation flag pass through a two-register output path to the output stream;
// the store is cleared for the next row at the edge that accepts that request.
// depends on mcdn_pkg, mcdn_min2, mcdn_lane, mcdn_merge
`default_nettype none

module min_cost_distinct_neighbor_dp #(
    parameter int MAX_CHOICES = mcdn_pkg::DEF_MAX_CHOICES,
    parameter int COST_WIDTH  = mcdn_pkg::DEF_COST_WIDTH,
    localparam int IN_W = ((MAX_CHOICES * COST_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mcdn_pkg::CFG_W-1:0]    i_cfg_wr_data,   // color_count
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [IN_W-1:0]               i_s_axis_tdata,  // cost_0, cost_1, ... upward
    input  wire logic                          i_s_axis_tlast,  // last_position
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic      [mcdn_pkg::SUM_W-1:0]    o_m_axis_tdata,  // min_total
    output logic                               o_m_axis_tuser   // saturated
);

    logic [mcdn_pkg::CFG_W-1:0]                    r_color_count;
    logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   r_path;
    logic                                          r_ovf;

    logic [mcdn_pkg::CFG_W-1:0]                    w_k;
    logic [MAX_CHOICES-1:0]                        w_active;
    logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   w_other;
    logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   w_store;
    logic [MAX_CHOICES-1:0][mcdn_pkg::SUM_W-1:0]   w_cand;
    logic [MAX_CHOICES-1:0]                        w_sat;
    logic                                          w_accept;
    logic                                          n_ovf;

    always_comb begin
        if (r_color_count < mcdn_pkg::MIN_CHOICES) begin
            w_k = mcdn_pkg::MIN_CHOICES;
        end else if (r_color_count > mcdn_pkg::CFG_W'(MAX_CHOICES)) begin
            w_k = mcdn_pkg::CFG_W'(MAX_CHOICES);
        end else begin
            w_k = r_color_count;
        end
    end

    for (genvar c = 0; c < MAX_CHOICES; c++) begin : g_lane
        assign w_active[c] = w_k > mcdn_pkg::CFG_W'(c);

        mcdn_lane #(
            .COST_WIDTH (COST_WIDTH)
        ) u_lane (
            .i_active (w_active[c]),
            .i_own    (i_s_axis_tdata[c*COST_WIDTH +: COST_WIDTH]),
            .i_other  (w_other[c]),
            .o_store  (w_store[c]),
            .o_cand   (w_cand[c]),
            .o_sat    (w_sat[c])
        );
    end

    mcdn_min2 #(
        .MAX_CHOICES (MAX_CHOICES)
    ) u_min2 (
        .i_active (w_active),
        .i_cost   (r_path),
        .o_other  (w_other)
    );

    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign n_ovf    = r_ovf | (|w_sat);

    mcdn_merge #(
        .MAX_CHOICES (MAX_CHOICES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept & i_s_axis_tlast),
        .i_cand      (w_cand),
        .i_sat       (n_ovf),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_min       (o_m_axis_tdata),
        .o_sat       (o_m_axis_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count <= mcdn_pkg::CFG_RESET;
            r_path        <= '0;
            r_ovf         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color_count <= i_cfg_wr_data;
            end
            if (w_accept) begin
                if (i_s_axis_tlast) begin
                    r_path <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_path <= w_store;
                    r_ovf  <= n_ovf;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/mcdn_row_checker.sv =====
// passive checker for min_cost_distinct_neighbor_dp: tracks color_count writes and input
// requests, predicts each row minimum and compares it with the output stream
// depends on mcdn_pkg
`default_nettype none

module mcdn_row_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mcdn_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          i_s_tready,
    input  wire logic [127:0]                  i_s_tdata,   // cost_0 .. cost_7
    input  wire logic                          i_s_tlast,   // last_position
    input  wire logic                          i_m_tvalid,
    input  wire logic                          i_m_tready,
    input  wire logic [mcdn_pkg::SUM_W-1:0]    i_m_tdata,   // min_total
    input  wire logic                          i_m_tuser,   // saturated
    output int                                 o_pending,
    output int                                 o_fail_count,
    output int                                 o_rows_seen,
    output int                                 o_sat_rows
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = mcdn_pkg::DEF_MAX_CHOICES;
    localparam int CW  = mcdn_pkg::DEF_COST_WIDTH;
    localparam int SW  = mcdn_pkg::SUM_W;

    typedef logic [NCH-1:0][CW-1:0] cost_row_t;

    typedef struct packed {
        logic [SW-1:0] total;
        logic          sat;
    } row_result_t;

    logic [SW-1:0]               path_cost [NCH];
    logic                        overflow_seen;
    logic [mcdn_pkg::CFG_W-1:0]  color_count;
    row_result_t                 row_minima_q [$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        o_rows_seen  = 0;
        o_sat_rows   = 0;
    end

    task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                   input logic [SW-1:0] want);
        o_fail_count++;
        if (o_fail_count <= 40)
            $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic clear_store();
        for (int c = 0; c < NCH; c++) path_cost[c] = '0;
        overflow_seen = 1'b0;
    endtask

    // one position of the row: every active choice adds the cheapest other stored path
    task automatic advance_row(input cost_row_t costs, input logic last);
        int            active;
        int            best_at;
        logic [SW-1:0] best;
        logic [SW-1:0] second;
        logic [SW-1:0] lowest;
        logic [SW:0]   sum;
        logic [SW-1:0] fresh [NCH];
        row_result_t   res;
        active = int'(color_count);
        if (active < int'(mcdn_pkg::MIN_CHOICES)) active = int'(mcdn_pkg::MIN_CHOICES);
        if (active > NCH) active = NCH;
        best    = mcdn_pkg::SUM_CEIL;
        second  = mcdn_pkg::SUM_CEIL;
        best_at = 0;
        for (int c = 0; c < active; c++) begin
            if (c == 0 || path_cost[c] < best) begin
                if (c != 0) second = best;
                best    = path_cost[c];
                best_at = c;
            end else if (path_cost[c] < second) begin
                second = path_cost[c];
            end
        end
        lowest = mcdn_pkg::SUM_CEIL;
        for (int c = 0; c < NCH; c++) begin
            fresh[c] = '0;
            if (c < active) begin
                sum = {1'b0, (c == best_at) ? second : best} + (SW+1)'(costs[c]);
                if (sum > {1'b0, mcdn_pkg::SUM_CEIL}) begin
                    sum           = {1'b0, mcdn_pkg::SUM_CEIL};
                    overflow_seen = 1'b1;
                end
                fresh[c] = sum[SW-1:0];
                if (fresh[c] < lowest) lowest = fresh[c];
            end
        end
        if (last) begin
            res.total = lowest;
            res.sat   = overflow_seen;
            row_minima_q.push_back(res);
            clear_store();
        end else begin
            for (int c = 0; c < NCH; c++) path_cost[c] = fresh[c];
        end
    endtask

    always @(posedge i_clk) begin
        row_result_t want;
        if (!i_rst_n) begin
            clear_store();
            color_count = mcdn_pkg::CFG_RESET;
            row_minima_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) advance_row(i_s_tdata, i_s_tlast);
            if (i_cfg_wr_en) color_count = i_cfg_wr_data;
            if (i_m_tvalid && i_m_tready) begin
                if (row_minima_q.size() == 0) begin
                    report_mismatch("unrequested result", i_m_tdata, '0);
                end else begin
                    want = row_minima_q.pop_front();
                    o_rows_seen++;
                    if (want.sat) o_sat_rows++;
                    if (i_m_tdata !== want.total)
                        report_mismatch("min_total", i_m_tdata, want.total);
                    if (i_m_tuser !== want.sat)
                        report_mismatch("saturated", SW'(i_m_tuser), SW'(want.sat));
                end
            end
        end
        o_pending <= row_minima_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench top for min_cost_distinct_neighbor_dp: drives rows of cost requests and
// color_count writes with random idling, and gives the verdict from the row checker
// depends on mcdn_pkg, mcdn_row_checker and the block under test
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH          = mcdn_pkg::DEF_MAX_CHOICES;
    localparam int CW           = mcdn_pkg::DEF_COST_WIDTH;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = 6;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef logic [NCH-1:0][CW-1:0] cost_row_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [mcdn_pkg::CFG_W-1:0]    i_cfg_wr_data = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [127:0]                  i_s_axis_tdata = '0;
    logic                          i_s_axis_tlast = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [mcdn_pkg::SUM_W-1:0]    o_m_axis_tdata;
    logic                          o_m_axis_tuser;

    int pending;
    int fail_count;
    int rows_seen;
    int sat_rows;
    int cycle_count = 0;
    int positions_sent = 0;
    int settings_used = 0;
    bit steady = 1'b0;

    min_cost_distinct_neighbor_dp dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    mcdn_row_checker row_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tlast     (i_s_axis_tlast),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tuser     (o_m_axis_tuser),
        .o_pending     (pending),
        .o_fail_count  (fail_count),
        .o_rows_seen   (rows_seen),
        .o_sat_rows    (sat_rows)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d rows outstanding", cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic cost_row_t uniform(input logic [CW-1:0] v);
        cost_row_t r;
        for (int c = 0; c < NCH; c++) r[c] = v;
        return r;
    endfunction

    function automatic cost_row_t ramp(input logic [CW-1:0] base, input logic [CW-1:0] step);
        cost_row_t r;
        for (int c = 0; c < NCH; c++) r[c] = base + CW'(c) * step;
        return r;
    endfunction

    function automatic cost_row_t random_row();
        cost_row_t r;
        for (int c = 0; c < NCH; c++) begin
            case ($urandom_range(9))
                0:       r[c] = '0;
                1:       r[c] = '1;
                2, 3, 4: r[c] = CW'($urandom_range(15));
                default: r[c] = CW'($urandom);
            endcase
        end
        return r;
    endfunction

    task automatic put_position(input cost_row_t costs, input logic last);
        while (!steady && $urandom_range(99) < 19) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= costs;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        positions_sent++;
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_color_count(input logic [mcdn_pkg::CFG_W-1:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random_rows();
        logic [mcdn_pkg::CFG_W-1:0] sweep [12] = '{2, 8, 0, 15, 5, 1, 9, 7, 4, 6, 3, 12};
        int  sent;
        int  in_phase;
        int  len;
        int  phase;
        bit  open_row;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            set_color_count(phase < 12 ? sweep[phase] : mcdn_pkg::CFG_W'($urandom_range(15)));
            steady   = (phase == 5 || phase == 6);
            in_phase = 0;
            while (in_phase < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                // an unfinished row carries over into the next count setting
                open_row = (in_phase + len >= PHASE_ITEMS) && ($urandom_range(2) == 0);
                for (int p = 0; p < len; p++)
                    put_position(random_row(), (p == len - 1) && !open_row);
                in_phase += len;
                sent     += len;
            end
            phase++;
        end
        steady = 1'b0;
        put_position(random_row(), 1'b1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of three, single-position rows and extremes
        put_position(ramp(0, 1), 1'b1);
        put_position(uniform('1), 1'b1);
        put_position(ramp(10, 5), 1'b0);
        put_position(ramp(40, 16'hFFFB), 1'b0);
        put_position(uniform(7), 1'b1);
        // equal stored costs
        put_position(uniform(5), 1'b0);
        put_position(uniform(5), 1'b1);

        // counts below two act as two; cheaper lanes above are ignored
        set_color_count(0);
        put_position(ramp('1, '1), 1'b0);
        put_position(ramp(16'hFFF0, '1), 1'b1);
        set_color_count(1);
        put_position(ramp('1, '1), 1'b0);
        put_position(uniform(0), 1'b1);
        set_color_count(8);
        put_position(ramp(100, '1), 1'b0);
        put_position(ramp(3, 7), 1'b0);
        put_position(uniform('1), 1'b1);
        // counts above eight act as eight
        set_color_count(15);
        put_position(ramp(16'h8000, 16'h1001), 1'b0);
        put_position(ramp(9, 16'hFFFE), 1'b1);

        // count raised in the middle of a row
        set_color_count(2);
        put_position(ramp(1, 1), 1'b0);
        put_position(ramp(20, 3), 1'b0);
        set_color_count(8);
        put_position(ramp(50, 16'hFFF6), 1'b1);

        run_random_rows();

        set_color_count(2);
        put_position(ramp(2, 2), 1'b1);

        settle();
        $display("run covered %0d positions in %0d rows over %0d color_count writes",
                 positions_sent, rows_seen, settings_used);
        $display("rows with a saturated path: %0d, cycles: %0d", sat_rows, cycle_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
